@@ src/mclf_pkg.sv @@
// Shared types and constants of the multi-channel LED fader.
// Used by every module of the block; depends on nothing.
`default_nettype none

package mclf_pkg;

  localparam int CHANNELS = 8;
  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int LVL_W    = 16;
  localparam int CFG_W    = 16;
  localparam int OCH_W    = 3;
  localparam int MS_TO_US = 1000;
  // widest step delay: longest fade time in microseconds
  localparam int DLY_W    = $clog2(((2 ** CFG_W) - 1) * MS_TO_US + 1);
  localparam int Q_DEPTH  = 2;

  // input opcodes
  localparam logic [2:0] OP_SET    = 3'd0;
  localparam logic [2:0] OP_START  = 3'd1;
  localparam logic [2:0] OP_ALLOFF = 3'd2;
  localparam logic [2:0] OP_TICK   = 3'd3;
  localparam logic [2:0] OP_APPLY  = 3'd4;

  // configuration register indexes
  localparam logic [1:0] REG_FADE_TIME  = 2'd0;
  localparam logic [1:0] REG_FALLBACK   = 2'd1;
  localparam logic [1:0] REG_STEP_LIMIT = 2'd2;

  localparam logic [CFG_W-1:0] FADE_TIME_RST  = CFG_W'(0);
  localparam logic [CFG_W-1:0] FALLBACK_RST   = CFG_W'(1000);
  localparam logic [CFG_W-1:0] STEP_LIMIT_RST = CFG_W'(1000);

  typedef enum logic [2:0] {
    CMD_SET,
    CMD_START,
    CMD_ALLOFF,
    CMD_TICK,
    CMD_APPLY
  } cmd_e;

  typedef struct packed {
    cmd_e              op;
    logic [CH_W-1:0]   chan;
    logic [LVL_W-1:0]  level;
  } cmd_t;

  typedef struct packed {
    logic [CFG_W-1:0] fade_time_ms;
    logic [CFG_W-1:0] fallback_step_delay_us;
    logic [CFG_W-1:0] step_limit;
  } cfg_t;

  typedef struct packed {
    logic [OCH_W-1:0] chan;
    logic [LVL_W-1:0] duty;
    logic             last;
    logic             fade_done;
  } beat_t;

endpackage

`default_nettype wire

@@ src/multi_channel_led_fader.sv @@
// Top level of the multi-channel LED fader: configuration registers and the
// front end, command queue and fade engine. Depends on mclf_pkg, mclf_front, mclf_queue and mclf_back.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o): one beat carries opcode_i, channel_i
//   and level_i. Opcodes: set target, start fade, all off and fade, one-microsecond
//   tick, apply directly. A beat enters a two-entry queue; in_stall_o rises only
//   when that queue is full, so input keeps flowing while results wait.
//   Output channel (out_valid_o / out_stall_i): one beat per PWM duty write, with
//   last_o on the final beat caused by an input beat and fade_done_o on every beat
//   of the run that writes all targets at the end of a fade.
//   Configuration (cfg_valid_i / cfg_ready_o): cfg_index_i selects fade time,
//   fallback step delay or step limit; cfg_ready_o is always high.
// Sequence: a set target or a counting tick is handled in the idle state. A start walks
//   the channels for the largest gap, then, with a nonzero fade time, runs a
//   one-bit-per-cycle divider, then a step walk of the channels. A step or target
//   run walks the channels in order.
// Reset: all levels, targets and fade state clear; registers take 0, 1000, 1000.
// A stalled output beat holds; the engine waits, and the queue fills behind it.
`default_nettype none

module multi_channel_led_fader (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [2:0]                  opcode_i,
  input  wire logic [2:0]                  channel_i,
  input  wire logic [mclf_pkg::LVL_W-1:0]  level_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [mclf_pkg::OCH_W-1:0]       out_channel_o,
  output logic [mclf_pkg::LVL_W-1:0]       duty_o,
  output logic                             last_o,
  output logic                             fade_done_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [1:0]                  cfg_index_i,
  input  wire logic [mclf_pkg::CFG_W-1:0]  cfg_data_i
);

  mclf_pkg::cfg_t  cfg_q, cfg_d;
  mclf_pkg::cmd_t  push_cmd, pop_cmd;
  mclf_pkg::beat_t beat;
  logic            push, q_full, q_empty, pop;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        mclf_pkg::REG_FADE_TIME:  cfg_d.fade_time_ms           = cfg_data_i;
        mclf_pkg::REG_FALLBACK:   cfg_d.fallback_step_delay_us = cfg_data_i;
        mclf_pkg::REG_STEP_LIMIT: cfg_d.step_limit             = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fade_time_ms           <= mclf_pkg::FADE_TIME_RST;
      cfg_q.fallback_step_delay_us <= mclf_pkg::FALLBACK_RST;
      cfg_q.step_limit             <= mclf_pkg::STEP_LIMIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  mclf_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .opcode_i   (opcode_i),
    .channel_i  (channel_i),
    .level_i    (level_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  mclf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .cmd_o   (pop_cmd)
  );

  mclf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (pop_cmd),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .cfg_i       (cfg_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .beat_o      (beat)
  );

  assign out_channel_o = beat.chan;
  assign duty_o        = beat.duty;
  assign last_o        = beat.last;
  assign fade_done_o   = beat.fade_done;

endmodule

`default_nettype wire

@@ src/mclf_front.sv @@
// Front end: accepts input beats, decodes the opcode and drops unknown opcodes and out-of-range sets.
// Depends on mclf_pkg.
`default_nettype none

module mclf_front (
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic [2:0]                opcode_i,
  input  wire logic [2:0]                channel_i,
  input  wire logic [mclf_pkg::LVL_W-1:0] level_i,
  input  wire logic                      q_full_i,
  output logic                           push_o,
  output mclf_pkg::cmd_t                 cmd_o
);

  logic keep;

  assign in_stall_o = q_full_i;

  always_comb begin
    keep         = 1'b1;
    cmd_o.op     = mclf_pkg::CMD_TICK;
    cmd_o.chan   = mclf_pkg::CH_W'(channel_i);
    cmd_o.level  = level_i;
    unique case (opcode_i)
      mclf_pkg::OP_SET: begin
        cmd_o.op = mclf_pkg::CMD_SET;
        keep     = 32'(channel_i) < 32'(mclf_pkg::CHANNELS);
      end
      mclf_pkg::OP_START:  cmd_o.op = mclf_pkg::CMD_START;
      mclf_pkg::OP_ALLOFF: cmd_o.op = mclf_pkg::CMD_ALLOFF;
      mclf_pkg::OP_TICK:   cmd_o.op = mclf_pkg::CMD_TICK;
      mclf_pkg::OP_APPLY:  cmd_o.op = mclf_pkg::CMD_APPLY;
      default:             keep = 1'b0;
    endcase
  end

  // drop unknown opcodes and out-of-range channels at the door
  assign push_o = in_valid_i && !q_full_i && keep;

endmodule

`default_nettype wire

@@ src/mclf_queue.sv @@
// Short command queue between the front end and the fade engine.
// Depends on mclf_pkg.
`default_nettype none

module mclf_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  mclf_pkg::cmd_t      cmd_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                empty_o,
  output mclf_pkg::cmd_t      cmd_o
);

  localparam int PTR_W = (mclf_pkg::Q_DEPTH > 1) ? $clog2(mclf_pkg::Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(mclf_pkg::Q_DEPTH + 1);

  mclf_pkg::cmd_t   mem_q [mclf_pkg::Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == CNT_W'(mclf_pkg::Q_DEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(mclf_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(mclf_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

@@ src/mclf_div.sv @@
// Restoring divider for the step delay, one quotient bit per cycle.
// Depends on mclf_pkg.
`default_nettype none

module mclf_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [mclf_pkg::DLY_W-1:0] dividend_i,
  input  wire logic [mclf_pkg::LVL_W-1:0] divisor_i,
  output logic                            done_o,
  output logic [mclf_pkg::DLY_W-1:0]      quotient_o
);

  localparam int DW    = mclf_pkg::DLY_W;
  localparam int LW    = mclf_pkg::LVL_W;
  localparam int CNT_W = $clog2(DW + 1);

  logic [LW-1:0]    rem_q, rem_d;
  logic [DW-1:0]    quo_q, quo_d;
  logic [LW-1:0]    dvs_q, dvs_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [LW:0]      shifted, trial;
  logic             fits;

  assign shifted    = {rem_q, quo_q[DW-1]};
  assign trial      = shifted - {1'b0, dvs_q};
  assign fits       = shifted >= {1'b0, dvs_q};
  assign done_o     = done_q;
  assign quotient_o = quo_q;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
      cnt_d  = CNT_W'(DW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? trial[LW-1:0] : shifted[LW-1:0];
      quo_d = {quo_q[DW-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

endmodule

`default_nettype wire

@@ src/mclf_back.sv @@
// Fade engine: holds channel levels, runs fades and writes duty beats.
// Depends on mclf_pkg and mclf_div.
`default_nettype none

module mclf_back (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  mclf_pkg::cmd_t cmd_i,
  input  wire logic      empty_i,
  output logic           pop_o,
  input  mclf_pkg::cfg_t cfg_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output mclf_pkg::beat_t beat_o
);

  localparam int CH = mclf_pkg::CHANNELS;
  localparam int CW = mclf_pkg::CH_W;
  localparam int LW = mclf_pkg::LVL_W;
  localparam int DW = mclf_pkg::DLY_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_GAP  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_STEP = 3'd3;
  localparam logic [2:0] S_TGT  = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [LW-1:0] cur_q [CH];
  logic [LW-1:0] cur_d [CH];
  logic [LW-1:0] tgt_q [CH];
  logic [LW-1:0] tgt_d [CH];
  logic          fading_q, fading_d;
  logic [LW-1:0] steps_q, steps_d;
  logic [DW-1:0] delay_q, delay_d;
  logic [DW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [LW-1:0] gap_q, gap_d;
  logic [CH-1:0] mask_q, mask_d;
  logic          done_q, done_d;
  logic          out_valid_q, out_valid_d;
  mclf_pkg::beat_t beat_q, beat_d;

  logic          emit, slot_free, idx_last, begin_fade, fade_go;
  logic [CH-1:0] mask_c;
  logic [LW-1:0] cur_sel, tgt_sel, diff, gap_nx, moved;
  logic [DW-1:0] cnt_inc, dividend, quotient;
  logic          div_start, div_done;

  mclf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (gap_nx),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_comb begin
    for (int c = 0; c < CH; c++) begin
      mask_c[c] = cur_q[c] != tgt_q[c];
    end
  end

  assign cur_sel   = cur_q[idx_q];
  assign tgt_sel   = tgt_q[idx_q];
  assign diff      = (cur_sel > tgt_sel) ? cur_sel - tgt_sel : tgt_sel - cur_sel;
  assign gap_nx    = (diff > gap_q) ? diff : gap_q;
  assign moved     = (cur_sel < tgt_sel) ? cur_sel + 1'b1 : cur_sel - 1'b1;
  assign slot_free = !out_valid_q || !out_stall_i;
  assign idx_last  = idx_q == CW'(CH - 1);
  assign cnt_inc   = count_q + 1'b1;
  assign dividend  = DW'(cfg_i.fade_time_ms) * DW'(mclf_pkg::MS_TO_US);
  assign out_valid_o = out_valid_q;
  assign beat_o      = beat_q;

  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    tgt_d      = tgt_q;
    fading_d   = fading_q;
    steps_d    = steps_q;
    delay_d    = delay_q;
    count_d    = count_q;
    idx_d      = idx_q;
    gap_d      = gap_q;
    mask_d     = mask_q;
    done_d     = done_q;
    pop_o      = 1'b0;
    emit       = 1'b0;
    beat_d     = beat_q;
    div_start  = 1'b0;
    begin_fade = 1'b0;
    fade_go    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          if (fading_q) begin
            // only ticks count while a fade runs
            if (cmd_i.op == mclf_pkg::CMD_TICK) begin
              if (cnt_inc < delay_q) begin
                count_d = cnt_inc;
              end else begin
                count_d = '0;
                if (steps_q >= cfg_i.step_limit || mask_c == '0) begin
                  fading_d = 1'b0;
                  state_d  = S_TGT;
                  idx_d    = '0;
                  done_d   = 1'b1;
                end else begin
                  state_d = S_STEP;
                  idx_d   = '0;
                  mask_d  = mask_c;
                  steps_d = steps_q + 1'b1;
                end
              end
            end
          end else begin
            unique case (cmd_i.op)
              mclf_pkg::CMD_SET:   tgt_d[cmd_i.chan] = cmd_i.level;
              mclf_pkg::CMD_START: begin_fade = 1'b1;
              mclf_pkg::CMD_ALLOFF: begin
                for (int c = 0; c < CH; c++) begin
                  tgt_d[c] = '0;
                end
                begin_fade = 1'b1;
              end
              mclf_pkg::CMD_TICK: ;
              mclf_pkg::CMD_APPLY: begin
                state_d = S_TGT;
                idx_d   = '0;
                done_d  = 1'b0;
              end
              default: ;
            endcase
            if (begin_fade) begin
              idx_d  = '0;
              done_d = 1'b1;
              if (cfg_i.step_limit == '0) begin
                state_d = S_TGT;
              end else begin
                state_d = S_GAP;
                gap_d   = '0;
              end
            end
          end
        end
      end
      S_GAP: begin
        gap_d = gap_nx;
        if (idx_last) begin
          idx_d = '0;
          if (gap_nx == '0) begin
            state_d = S_TGT;
            done_d  = 1'b1;
          end else if (cfg_i.fade_time_ms != '0) begin
            div_start = 1'b1;
            state_d   = S_DIV;
          end else begin
            delay_d = DW'(cfg_i.fallback_step_delay_us);
            fade_go = 1'b1;
          end
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_DIV: begin
        if (div_done) begin
          delay_d = quotient;
          fade_go = 1'b1;
        end
      end
      S_STEP: begin
        if (!mask_q[idx_q] || slot_free) begin
          if (mask_q[idx_q]) begin
            cur_d[idx_q]     = moved;
            emit             = 1'b1;
            beat_d.chan      = mclf_pkg::OCH_W'(idx_q);
            beat_d.duty      = moved;
            beat_d.last      = (mask_q >> idx_q) == CH'(1);
            beat_d.fade_done = 1'b0;
          end
          if (idx_last) begin
            state_d = S_IDLE;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      S_TGT: begin
        if (slot_free) begin
          emit             = 1'b1;
          beat_d.chan      = mclf_pkg::OCH_W'(idx_q);
          beat_d.duty      = tgt_sel;
          beat_d.last      = idx_last;
          beat_d.fade_done = done_q;
          if (idx_last) begin
            state_d = S_IDLE;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase

    // first step of a new fade; the step counter already counts it
    if (fade_go) begin
      steps_d  = LW'(1);
      count_d  = '0;
      fading_d = 1'b1;
      mask_d   = mask_c;
      idx_d    = '0;
      state_d  = S_STEP;
    end

    if (emit) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      for (int c = 0; c < CH; c++) begin
        cur_q[c] <= '0;
        tgt_q[c] <= '0;
      end
      fading_q    <= 1'b0;
      steps_q     <= '0;
      delay_q     <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      gap_q       <= '0;
      mask_q      <= '0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      tgt_q       <= tgt_d;
      fading_q    <= fading_d;
      steps_q     <= steps_d;
      delay_q     <= delay_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      gap_q       <= gap_d;
      mask_q      <= mask_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      beat_q <= beat_d;
    end
  end

endmodule

`default_nettype wire

@@ src/mclf_checker.sv @@
// Port-level checks for the LED fader and the bind that attaches them.
// Depends on mclf_pkg and multi_channel_led_fader.
`default_nettype none

module mclf_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_valid_i,
  input wire logic                       in_stall_o,
  input wire logic [2:0]                 opcode_i,
  input wire logic [2:0]                 channel_i,
  input wire logic [mclf_pkg::LVL_W-1:0] level_i,
  input wire logic                       out_valid_o,
  input wire logic                       out_stall_i,
  input wire logic [mclf_pkg::OCH_W-1:0] out_channel_o,
  input wire logic [mclf_pkg::LVL_W-1:0] duty_o,
  input wire logic                       last_o,
  input wire logic                       fade_done_o,
  input wire logic                       cfg_valid_i,
  input wire logic                       cfg_ready_o,
  input wire logic [1:0]                 cfg_index_i,
  input wire logic [mclf_pkg::CFG_W-1:0] cfg_data_i
);

  localparam logic [2:0] LAST_CH = 3'(mclf_pkg::CHANNELS - 1);

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(duty_o) &&
    $stable(out_channel_o) && $stable(last_o) && $stable(fade_done_o))
    else $error("output beat changed while stalled");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

  // a closing target run ends exactly on the top channel
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fade_done_o |-> last_o == (out_channel_o == LAST_CH))
    else $error("target run ends on wrong channel");

  // a target run advances one channel per beat without gaps
  a_done_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && fade_done_o && !last_o |=>
    out_valid_o && fade_done_o && out_channel_o == 3'($past(out_channel_o) + 3'd1))
    else $error("target run broken");

endmodule

bind multi_channel_led_fader mclf_checker u_mclf_checker (.*);

`default_nettype wire

@@ tb/multi_channel_led_fader_tb.sv @@
// Self-checking testbench for the multi-channel LED fader: a directed table,
// then random fade sequences, each duty beat checked against a built-in fade predictor.
// Depends on mclf_pkg and multi_channel_led_fader.
`timescale 1ns / 1ps

module multi_channel_led_fader_tb;
  import mclf_pkg::*;

  localparam logic [2:0] OP_UNUSED5 = 3'd5;
  localparam logic [2:0] OP_UNUSED6 = 3'd6;
  localparam logic [2:0] OP_UNUSED7 = 3'd7;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int ANY         = -1;
  localparam int SETTLE_CYC  = 120;
  localparam int HOLD_CYC    = 500;
  localparam int PHASE_ITEMS = 22;
  localparam int LIMIT_CYC   = 2_000_000;

  logic              clk;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic [2:0]        opcode    = OP_SET;
  logic [2:0]        channel   = '0;
  logic [LVL_W-1:0]  level     = '0;
  logic              out_stall = 1'b0;
  logic              cfg_valid = 1'b0;
  logic [1:0]        cfg_index = REG_FADE_TIME;
  logic [CFG_W-1:0]  cfg_data  = '0;
  logic              in_stall;
  logic              out_valid;
  logic [OCH_W-1:0]  out_channel;
  logic [LVL_W-1:0]  duty;
  logic              last;
  logic              fade_done;
  logic              cfg_ready;

  multi_channel_led_fader u_top (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .opcode_i     (opcode),
    .channel_i    (channel),
    .level_i      (level),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .out_channel_o(out_channel),
    .duty_o       (duty),
    .last_o       (last),
    .fade_done_o  (fade_done),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // fade predictor state and register copies
  logic [LVL_W-1:0] cur_lvl [CHANNELS];
  logic [LVL_W-1:0] tgt_lvl [CHANNELS];
  bit               fade_on     = 1'b0;
  logic [15:0]      steps_taken = '0;
  logic [31:0]      step_dly    = '0;
  logic [31:0]      tick_cnt    = '0;
  logic [CFG_W-1:0] ft_r  = FADE_TIME_RST;
  logic [CFG_W-1:0] fb_r  = FALLBACK_RST;
  logic [CFG_W-1:0] lim_r = STEP_LIMIT_RST;

  beat_t new_duty_q[$];
  beat_t pending_duty_q[$];

  int  errors       = 0;
  int  useful_items = 0;
  int  burst_left   = 0;
  bit  hold_req     = 1'b0;
  bit  hold_done    = 1'b0;
  longint cycles    = 0;

  initial begin
    for (int c = 0; c < CHANNELS; c++) begin
      cur_lvl[c] = '0;
      tgt_lvl[c] = '0;
    end
  end

  function automatic void emit(input int c, input logic [LVL_W-1:0] d, input bit done);
    beat_t b;
    b.chan      = OCH_W'(c);
    b.duty      = d;
    b.last      = 1'b0;
    b.fade_done = done;
    new_duty_q.push_back(b);
  endfunction

  function automatic void emit_targets(input bit done);
    for (int c = 0; c < CHANNELS; c++) emit(c, tgt_lvl[c], done);
  endfunction

  function automatic void finish_fade();
    fade_on  = 1'b0;
    tick_cnt = '0;
    emit_targets(1'b1);
  endfunction

  // move every unequal channel one level toward its target
  function automatic int step_levels();
    int n;
    n = 0;
    for (int c = 0; c < CHANNELS; c++) begin
      if (cur_lvl[c] != tgt_lvl[c]) begin
        if (cur_lvl[c] < tgt_lvl[c]) cur_lvl[c] = cur_lvl[c] + 1'b1;
        else cur_lvl[c] = cur_lvl[c] - 1'b1;
        emit(c, cur_lvl[c], 1'b0);
        n++;
      end
    end
    return n;
  endfunction

  function automatic logic [LVL_W-1:0] widest_gap();
    logic [LVL_W-1:0] gap, d;
    gap = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      d = (cur_lvl[c] > tgt_lvl[c]) ? cur_lvl[c] - tgt_lvl[c] : tgt_lvl[c] - cur_lvl[c];
      if (d > gap) gap = d;
    end
    return gap;
  endfunction

  function automatic logic [31:0] start_delay();
    logic [LVL_W-1:0] gap;
    gap = widest_gap();
    if (gap == 0) return '0;
    if (ft_r != 0) return (32'(ft_r) * 32'(MS_TO_US)) / 32'(gap);
    return 32'(fb_r);
  endfunction

  function automatic void begin_fade();
    if (lim_r == 0 || widest_gap() == 0) begin
      emit_targets(1'b1);
    end else begin
      step_dly    = start_delay();
      tick_cnt    = '0;
      fade_on     = 1'b1;
      void'(step_levels());
      steps_taken = 16'd1;
    end
  endfunction

  function automatic void predict_duties(input logic [2:0] op, input logic [2:0] ch,
                                         input logic [LVL_W-1:0] lvl);
    new_duty_q.delete();
    if (fade_on) begin
      if (op == OP_TICK) begin
        tick_cnt = tick_cnt + 1;
        if (tick_cnt >= step_dly) begin
          tick_cnt = '0;
          if (steps_taken >= lim_r) finish_fade();
          else if (step_levels() == 0) finish_fade();
          else steps_taken = steps_taken + 1'b1;
        end
      end
    end else begin
      case (op)
        OP_SET: begin
          if (int'(ch) < CHANNELS) tgt_lvl[ch] = lvl;
        end
        OP_START: begin_fade();
        OP_ALLOFF: begin
          for (int c = 0; c < CHANNELS; c++) tgt_lvl[c] = '0;
          begin_fade();
        end
        OP_APPLY: emit_targets(1'b0);
        default: ;
      endcase
    end
    if (new_duty_q.size() > 0) new_duty_q[new_duty_q.size() - 1].last = 1'b1;
    foreach (new_duty_q[i]) pending_duty_q.push_back(new_duty_q[i]);
  endfunction

  task automatic send(input logic [2:0] op, input logic [2:0] ch, input logic [LVL_W-1:0] lvl);
    int idle;
    cfg_valid <= 1'b0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (idle > 0) begin
        in_valid <= 1'b0;
        repeat (idle) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    opcode   <= op;
    channel  <= ch;
    level    <= lvl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (fade_on ? (op == OP_TICK)
                : (op == OP_SET || op == OP_START || op == OP_ALLOFF || op == OP_APPLY))
      useful_items++;
    predict_duties(op, ch, lvl);
  endtask

  // drop valid, wait for every expected beat, then let the engine drain
  task automatic settle();
    in_valid  <= 1'b0;
    cfg_valid <= 1'b0;
    while (pending_duty_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_FADE_TIME:  ft_r  = val;
      REG_FALLBACK:   fb_r  = val;
      REG_STEP_LIMIT: lim_r = val;
      default: ;
    endcase
  endtask

  task automatic run_out_fade();
    while (fade_on) send(OP_TICK, 3'($urandom), LVL_W'($urandom));
  endtask

  function automatic logic [LVL_W-1:0] pick_level(input int c, input bit near);
    int r, v;
    r = $urandom_range(0, 9);
    if (near || r < 4) begin
      v = int'(cur_lvl[c]) + int'($urandom_range(0, 12)) - 6;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
    end else if (r == 4) begin
      v = 0;
    end else if (r == 5) begin
      v = 65535;
    end else begin
      v = $urandom_range(0, 65535);
    end
    return LVL_W'(v);
  endfunction

  // target writes, maybe an apply or noise, a start or all-off, then mostly ticks until the fade ends
  task automatic fade_sequence(input bit near);
    int nsets;
    int c;
    logic [2:0] op;
    nsets = $urandom_range(1, 4);
    repeat (nsets) begin
      c = $urandom_range(0, CHANNELS - 1);
      send(3'(OP_SET), 3'(c), pick_level(c, near));
    end
    if ($urandom_range(0, 5) == 0) send(OP_APPLY, 3'($urandom), LVL_W'($urandom));
    if ($urandom_range(0, 4) == 0) begin
      op = ($urandom_range(0, 3) == 0) ? OP_TICK : 3'($urandom_range(5, 7));
      send(op, 3'($urandom), LVL_W'($urandom));
    end
    // keep the latched delay short: push channel 0 far from its level
    if (ft_r != 0 && start_delay() > 8)
      send(OP_SET, 3'd0, (cur_lvl[0] < 16'h8000) ? 16'hFFFF : 16'h0000);
    op = (!near && ft_r == 0 && $urandom_range(0, 3) == 0) ? OP_ALLOFF : OP_START;
    send(op, 3'($urandom), LVL_W'($urandom));
    while (fade_on) begin
      if ($urandom_range(0, 7) == 0) begin
        op = 3'($urandom_range(0, 6));
        if (op >= OP_TICK) op = op + 1'b1;
      end else begin
        op = OP_TICK;
      end
      send(op, 3'($urandom), LVL_W'($urandom));
    end
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] ft, input logic [CFG_W-1:0] fb,
                           input logic [CFG_W-1:0] lim, input bit near, input bit hold);
    int first;
    settle();
    write_reg(REG_FADE_TIME, ft);
    write_reg(REG_FALLBACK, fb);
    write_reg(REG_STEP_LIMIT, lim);
    if (hold) hold_req = 1'b1;
    if (near)
      for (int c = 0; c < CHANNELS; c++) send(OP_SET, 3'(c), cur_lvl[c]);
    first = useful_items;
    while (useful_items - first < PHASE_ITEMS) fade_sequence(near);
  endtask

  typedef struct packed {
    bit               is_reg;
    logic [1:0]       reg_idx;
    logic [2:0]       op;
    logic [2:0]       ch;
    logic [LVL_W-1:0] val;
    int               n_beats;
    int               duty;
  } dir_row_t;

  dir_row_t dir_rows[$] = '{
    '{1'b0, REG_FADE_TIME,  OP_APPLY,   3'd0, 16'h0000, 8,   0},
    '{1'b0, REG_FADE_TIME,  OP_TICK,    3'd0, 16'h0000, 0,   ANY},
    '{1'b0, REG_FADE_TIME,  OP_START,   3'd0, 16'h0000, 8,   0},
    '{1'b0, REG_FADE_TIME,  OP_UNUSED5, 3'd0, 16'h0000, 0,   ANY},
    '{1'b0, REG_FADE_TIME,  OP_UNUSED6, 3'd0, 16'h0000, 0,   ANY},
    '{1'b0, REG_FADE_TIME,  OP_UNUSED7, 3'd7, 16'hFFFF, 0,   ANY},
    '{1'b0, REG_FADE_TIME,  OP_ALLOFF,  3'd0, 16'h0000, 8,   0},
    '{1'b0, REG_FADE_TIME,  OP_SET,     3'd7, 16'hFFFF, 0,   ANY},
    '{1'b0, REG_FADE_TIME,  OP_SET,     3'd0, 16'h0003, 0,   ANY},
    '{1'b0, REG_FADE_TIME,  OP_APPLY,   3'd0, 16'h0000, 8,   ANY},
    '{1'b1, REG_STEP_LIMIT, OP_SET,     3'd0, 16'd2,    ANY, ANY},
    '{1'b1, REG_FALLBACK,   OP_SET,     3'd0, 16'd0,    ANY, ANY},
    '{1'b0, REG_FADE_TIME,  OP_START,   3'd0, 16'h0000, 2,   1},
    // a fallback write mid-fade must not change the latched delay
    '{1'b1, REG_FALLBACK,   OP_SET,     3'd0, 16'd5,    ANY, ANY},
    '{1'b0, REG_FADE_TIME,  OP_SET,     3'd3, 16'd100,  0,   ANY},
    '{1'b0, REG_FADE_TIME,  OP_APPLY,   3'd0, 16'h0000, 0,   ANY},
    '{1'b0, REG_FADE_TIME,  OP_TICK,    3'd0, 16'h0000, 2,   2},
    '{1'b0, REG_FADE_TIME,  OP_TICK,    3'd0, 16'h0000, 8,   ANY},
    '{1'b1, REG_STEP_LIMIT, OP_SET,     3'd0, 16'd0,    ANY, ANY},
    '{1'b0, REG_FADE_TIME,  OP_START,   3'd0, 16'h0000, 8,   ANY},
    '{1'b0, REG_FADE_TIME,  OP_ALLOFF,  3'd0, 16'h0000, 8,   0},
    '{1'b1, REG_UNUSED,     OP_SET,     3'd0, 16'hFFFF, ANY, ANY},
    '{1'b1, REG_FADE_TIME,  OP_SET,     3'd0, 16'hFFFF, ANY, ANY},
    '{1'b1, REG_STEP_LIMIT, OP_SET,     3'd0, 16'd1,    ANY, ANY},
    '{1'b0, REG_FADE_TIME,  OP_SET,     3'd0, 16'hFFFF, 0,   ANY},
    '{1'b0, REG_FADE_TIME,  OP_START,   3'd0, 16'h0000, 2,   ANY}
  };

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_reg) begin
        settle();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].val);
      end else begin
        send(dir_rows[i].op, dir_rows[i].ch, dir_rows[i].val);
        if (dir_rows[i].n_beats != ANY && new_duty_q.size() != dir_rows[i].n_beats) begin
          $display("%0t: row %0d beat count: expected %0d, actual %0d", $time, i,
                   dir_rows[i].n_beats, new_duty_q.size());
          errors++;
        end
        if (dir_rows[i].duty != ANY)
          foreach (new_duty_q[k])
            if (new_duty_q[k].duty != LVL_W'(dir_rows[i].duty)) begin
              $display("%0t: row %0d duty: expected %0d, actual %0d", $time, i,
                       dir_rows[i].duty, new_duty_q[k].duty);
              errors++;
            end
      end
    end
    // longest fade time: about a thousand ticks per step
    run_out_fade();
    run_phase(16'd0, 16'd0, 16'd4, 1'b0, 1'b1);
    run_phase(16'd0, 16'd2, 16'd3, 1'b0, 1'b0);
    run_phase(16'd1, 16'hFFFF, 16'd5, 1'b0, 1'b0);
    run_phase(16'd0, 16'd1, 16'hFFFF, 1'b1, 1'b0);
    repeat (2)
      run_phase(CFG_W'($urandom_range(0, 2)), CFG_W'($urandom_range(0, 3)),
                CFG_W'($urandom_range(1, 8)), 1'b0, 1'b0);
    settle();
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // output stall pattern, plus one long hold-off on request
  initial begin : receiver
    int seg, pct;
    forever begin
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYC) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        seg = $urandom_range(1, 24);
        case ($urandom_range(0, 4))
          0, 1: pct = 0;
          2: pct = 30;
          3: pct = 60;
          default: pct = 95;
        endcase
        repeat (seg) begin
          out_stall <= ($urandom_range(0, 99) < pct);
          @(posedge clk);
        end
      end
    end
  end

  function automatic void check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : duty_monitor
    beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_duty_q.size() == 0) begin
        $display("%0t: unexpected beat: expected none, actual ch %0d duty %0d", $time,
                 out_channel, duty);
        errors++;
      end else begin
        want = pending_duty_q.pop_front();
        check_field("out_channel", want.chan, out_channel);
        check_field("duty", want.duty, duty);
        check_field("last", want.last, last);
        check_field("fade_done", want.fade_done, fade_done);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYC) begin
      $display("%0t: timeout with %0d beats outstanding", $time, pending_duty_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

endmodule
